// File: rtl/pssc_pkg.sv
`default_nettype none

package pssc_pkg;

    localparam int COORD_W = 25;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int D2_W    = SQ_W + 1;
    localparam int TOL_W   = 13;
    localparam int CUT_W   = 15;
    localparam int CENT_W  = 14;
    localparam int BAND_W  = 15;
    localparam int THR_W   = 2 * BAND_W;
    localparam int SEEN_W  = 3;
    localparam int CNT_W   = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [SEEN_W-1:0] SEEN_FULL = 3'd4;

    // band centers, milli-angstrom: index 0 two apart, 1 three apart, 2 four apart
    localparam logic [CENT_W-1:0] HELIX_C0  = 14'd5450;
    localparam logic [CENT_W-1:0] HELIX_C1  = 14'd5180;
    localparam logic [CENT_W-1:0] HELIX_C2  = 14'd6370;
    localparam logic [CENT_W-1:0] STRAND_C0 = 14'd6100;
    localparam logic [CENT_W-1:0] STRAND_C1 = 14'd10400;
    localparam logic [CENT_W-1:0] STRAND_C2 = 14'd13000;

    localparam logic [TOL_W-1:0] HELIX_TOL_RST  = 13'd2100;
    localparam logic [TOL_W-1:0] STRAND_TOL_RST = 13'd1420;
    localparam logic [CUT_W-1:0] TURN_CUT_RST   = 15'd8200;

    typedef enum logic [1:0] {
        CLASS_HELIX  = 2'd0,
        CLASS_STRAND = 2'd1,
        CLASS_TURN   = 2'd2,
        CLASS_LOOP   = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        REG_HELIX_TOL  = 2'd0,
        REG_STRAND_TOL = 2'd1,
        REG_TURN_CUT   = 2'd2
    } t_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic [THR_W-1:0] hi2;
        logic [THR_W-1:0] lo2;
        logic             lo_ok;
    } t_band;

    typedef struct packed {
        t_band [2:0]      hx;
        t_band [2:0]      st;
        logic [THR_W-1:0] turn2;
    } t_thr;

    typedef struct packed {
        logic             classify;
        logic [CNT_W-1:0] cnt;
    } t_meta;

    function automatic t_band make_band(input logic [CENT_W-1:0] centre,
                                        input logic [TOL_W-1:0] tol);
        logic [BAND_W-1:0] hi;
        logic [BAND_W-1:0] lo;
        t_band             b;
        hi      = BAND_W'(centre) + BAND_W'(tol);
        lo      = BAND_W'(centre) - BAND_W'(tol);
        b.hi2   = THR_W'(hi) * THR_W'(hi);
        b.lo2   = THR_W'(lo) * THR_W'(lo);
        b.lo_ok = (BAND_W'(tol) <= BAND_W'(centre));
        return b;
    endfunction

    function automatic logic in_band(input logic [D2_W-1:0] d2, input t_band b);
        return (d2 < D2_W'(b.hi2)) && (!b.lo_ok || (d2 > D2_W'(b.lo2)));
    endfunction

endpackage

`default_nettype wire

// File: rtl/pssc_cell.sv
`default_nettype none

module pssc_cell import pssc_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_shift,
    input  wire       i_clear,
    input  wire t_pos i_next,
    output t_pos      o_pos
);

    t_pos r_pos;
    t_pos n_pos;

    always_comb begin
        n_pos = r_pos;
        if (i_shift) begin
            n_pos = i_clear ? '0 : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

`default_nettype wire

// File: rtl/pssc_dist.sv
`default_nettype none

module pssc_dist import pssc_pkg::*; (
    input  wire              i_clk,
    input  wire              i_adv,
    input  wire t_pos        i_new,
    input  wire t_pos        i_old,
    output logic [D2_W-1:0]  o_dist2
);

    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [DIFF_W-1:0] r_dz;
    logic [SQ_W-1:0]          r_sx;
    logic [SQ_W-1:0]          r_sy;
    logic [SQ_W-1:0]          r_sz;
    logic [D2_W-1:0]          r_sum;

    function automatic logic [SQ_W-1:0] sq_mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        logic [2*DIFF_W-1:0] p;
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        p = (2*DIFF_W)'(m) * (2*DIFF_W)'(m);
        return p[SQ_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx  <= DIFF_W'(i_new.x) - DIFF_W'(i_old.x);
            r_dy  <= DIFF_W'(i_new.y) - DIFF_W'(i_old.y);
            r_dz  <= DIFF_W'(i_new.z) - DIFF_W'(i_old.z);
            r_sx  <= sq_mag(r_dx);
            r_sy  <= sq_mag(r_dy);
            r_sz  <= sq_mag(r_dz);
            r_sum <= D2_W'(r_sx) + D2_W'(r_sy) + D2_W'(r_sz);
        end
    end

    assign o_dist2 = r_sum;

endmodule

`default_nettype wire

// File: rtl/pssc_classify.sv
`default_nettype none

module pssc_classify import pssc_pkg::*; (
    input  wire              i_clk,
    input  wire              i_adv,
    input  wire              i_valid,
    input  wire [D2_W-1:0]   i_d15,
    input  wire [D2_W-1:0]   i_d25,
    input  wire [D2_W-1:0]   i_d35,
    input  wire t_thr        i_thr,
    output t_class           o_class
);

    // distances of earlier items that reappear in this window
    logic [D2_W-1:0] r_d25_p;
    logic [D2_W-1:0] r_d35_p;
    logic [D2_W-1:0] r_d35_pp;

    logic helix;
    logic strand;

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_d25_p  <= i_d25;
            r_d35_p  <= i_d35;
            r_d35_pp <= r_d35_p;
        end
    end

    always_comb begin
        helix  = in_band(r_d35_pp, i_thr.hx[0]) && in_band(r_d35_p, i_thr.hx[0])
              && in_band(i_d35, i_thr.hx[0]) && in_band(r_d25_p, i_thr.hx[1])
              && in_band(i_d25, i_thr.hx[1]) && in_band(i_d15, i_thr.hx[2]);
        strand = in_band(r_d35_pp, i_thr.st[0]) && in_band(r_d35_p, i_thr.st[0])
              && in_band(i_d35, i_thr.st[0]) && in_band(r_d25_p, i_thr.st[1])
              && in_band(i_d25, i_thr.st[1]) && in_band(i_d15, i_thr.st[2]);
        if (helix) begin
            o_class = CLASS_HELIX;
        end else if (strand) begin
            o_class = CLASS_STRAND;
        end else if (i_d15 < D2_W'(i_thr.turn2)) begin
            o_class = CLASS_TURN;
        end else begin
            o_class = CLASS_LOOP;
        end
    end

endmodule

`default_nettype wire

// File: rtl/protein_secondary_structure_classifier_core.sv
`default_nettype none

// Secondary-structure classifier for a stream of alpha-carbon positions.
// Input channel (i_valid / o_stall): one residue per item, x/y/z in signed
// milli-angstrom and i_chain_end on the last residue of a chain.
// Output channel (o_valid / i_stall): one class per item, 0 helix, 1 strand,
// 2 turn, 3 loop; o_run_last marks the last result of an input item.
// An item gives zero or one result, a chain-end item up to three.
// The first result of an item passes the difference register, loaded at the edge
// that accepts the item, then the square, sum and output registers.
// Throughput: one item per cycle while each item yields at most one result and
// the output is not stalled; an item with more results holds the input while the
// single output register drains them, one result per cycle while i_stall is low.
// A chain of four cells holds the last four residues; three distance pipes
// measure the new residue against the three oldest cells.
// A stall on the output while a result waits freezes the whole pipeline and
// raises o_stall.
// Reset (synchronous, active low) empties the pipeline, clears the window and
// residue count and loads the tolerance and cutoff registers with defaults.
// The user must write tolerances and cutoff over APB only while the block is idle; the block does not enforce it.

module protein_secondary_structure_classifier_core import pssc_pkg::*; (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire signed [COORD_W-1:0]   i_coord_x,
    input  wire signed [COORD_W-1:0]   i_coord_y,
    input  wire signed [COORD_W-1:0]   i_coord_z,
    input  wire                        i_chain_end,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic [1:0]                 o_ss_class,
    output logic                       o_run_last,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [PADDR_W-1:0]          paddr,
    input  wire [PDATA_W-1:0]          pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    logic [TOL_W-1:0]  r_helix_tol;
    logic [TOL_W-1:0]  r_strand_tol;
    logic [CUT_W-1:0]  r_turn_cut;
    t_thr              r_thr;
    t_thr              n_thr;
    t_reg              cfg_idx;
    logic              cfg_wr;

    logic              adv;
    logic              acc;
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    t_meta             acc_meta;
    logic              r_v1, r_v2, r_v3;
    t_meta             r_m1, r_m2, r_m3;

    t_pos              new_pos;
    t_pos              win [0:4];
    logic [D2_W-1:0]   dist2 [0:2];
    t_class            cls;

    logic              r_ob_valid;
    t_class            r_ob_cls;
    logic [CNT_W-1:0]  r_ob_left;
    logic              n_ob_valid;
    t_class            n_ob_cls;
    logic [CNT_W-1:0]  n_ob_left;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_helix_tol  <= HELIX_TOL_RST;
            r_strand_tol <= STRAND_TOL_RST;
            r_turn_cut   <= TURN_CUT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HELIX_TOL:  r_helix_tol  <= pwdata[TOL_W-1:0];
                REG_STRAND_TOL: r_strand_tol <= pwdata[TOL_W-1:0];
                REG_TURN_CUT:   r_turn_cut   <= pwdata[CUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HELIX_TOL:  prdata = PDATA_W'(r_helix_tol);
            REG_STRAND_TOL: prdata = PDATA_W'(r_strand_tol);
            REG_TURN_CUT:   prdata = PDATA_W'(r_turn_cut);
            default:        prdata = '0;
        endcase
    end

    // squared band limits
    always_comb begin
        n_thr.hx[0] = make_band(HELIX_C0, r_helix_tol);
        n_thr.hx[1] = make_band(HELIX_C1, r_helix_tol);
        n_thr.hx[2] = make_band(HELIX_C2, r_helix_tol);
        n_thr.st[0] = make_band(STRAND_C0, r_strand_tol);
        n_thr.st[1] = make_band(STRAND_C1, r_strand_tol);
        n_thr.st[2] = make_band(STRAND_C2, r_strand_tol);
        n_thr.turn2 = THR_W'(r_turn_cut) * THR_W'(r_turn_cut);
    end

    always_ff @(posedge i_clk) begin
        r_thr <= n_thr;
    end

    // input side
    assign adv     = !r_ob_valid || ((r_ob_left == '0) && !i_stall);
    assign o_stall = !adv;
    assign acc     = i_valid && adv;

    always_comb begin
        acc_meta.classify = (r_seen == SEEN_FULL);
        acc_meta.cnt      = (r_seen >= 3'd2) ? 2'd1 : 2'd0;
        if (i_chain_end) begin
            acc_meta.cnt = acc_meta.cnt + ((r_seen != '0) ? 2'd2 : 2'd1);
        end
        n_seen = r_seen;
        if (acc) begin
            if (i_chain_end) begin
                n_seen = '0;
            end else if (r_seen != SEEN_FULL) begin
                n_seen = r_seen + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            r_seen <= n_seen;
            if (adv) begin
                r_v1 <= acc;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1 <= acc_meta;
            r_m2 <= r_m1;
            r_m3 <= r_m2;
        end
    end

    // window cells and distance pipes
    assign new_pos.x = i_coord_x;
    assign new_pos.y = i_coord_y;
    assign new_pos.z = i_coord_z;
    assign win[4]    = new_pos;

    for (genvar k = 0; k < 4; k++) begin : g_cell
        pssc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (acc),
            .i_clear (i_chain_end),
            .i_next  (win[k+1]),
            .o_pos   (win[k])
        );
    end

    for (genvar k = 0; k < 3; k++) begin : g_dist
        pssc_dist u_dist (
            .i_clk   (i_clk),
            .i_adv   (adv),
            .i_new   (new_pos),
            .i_old   (win[k]),
            .o_dist2 (dist2[k])
        );
    end

    pssc_classify u_classify (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_valid (r_v3),
        .i_d15   (dist2[0]),
        .i_d25   (dist2[1]),
        .i_d35   (dist2[2]),
        .i_thr   (r_thr),
        .o_class (cls)
    );

    // output register, drains the results of one item
    always_comb begin
        n_ob_valid = r_ob_valid;
        n_ob_cls   = r_ob_cls;
        n_ob_left  = r_ob_left;
        if (adv) begin
            if (r_v3 && (r_m3.cnt != '0)) begin
                n_ob_valid = 1'b1;
                n_ob_cls   = r_m3.classify ? cls : CLASS_LOOP;
                n_ob_left  = r_m3.cnt - 2'd1;
            end else begin
                n_ob_valid = 1'b0;
            end
        end else if (!i_stall) begin
            n_ob_cls  = CLASS_LOOP;
            n_ob_left = r_ob_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_ob_left  <= '0;
        end else begin
            r_ob_valid <= n_ob_valid;
            r_ob_left  <= n_ob_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob_cls <= n_ob_cls;
    end

    assign o_valid    = r_ob_valid;
    assign o_ss_class = r_ob_cls;
    assign o_run_last = (r_ob_left == '0);

    // checks
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_FULL)
        else $error("residue count out of range");

    a_chain_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && acc && i_chain_end |=> r_seen == '0)
        else $error("chain end did not clear residue count");

    a_tail_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_valid && !i_stall && !o_run_last |=> o_valid && o_ss_class == CLASS_LOOP)
        else $error("trailing result missing or not loop");

    a_classify_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_m3.classify |-> r_m3.cnt != '0)
        else $error("classified item without result");

endmodule

`default_nettype wire
